>>> sv/sipab_pkg.sv
package sipab_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned BASE_LEN_W  = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned ALPHA_CHARS = 16;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned WIDE_W      = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN = 2'd2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic [BASE_LEN_W-1:0] MIN_BASE_LEN = 5'd2;

  // One classified character
  typedef struct packed {
    logic               last;
    logic               space;
    logic               plus;
    logic               minus;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [BASE_LEN_W-1:0] radix;
    logic                  base_valid;
  } cfg_t;

endpackage

>>> sv/sipab_front.sv
module sipab_front import sipab_pkg::*; #(
  parameter int unsigned MAX_BASE_LENGTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CHAR_W-1:0]     char_in_i,
  input  logic                  is_last_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output item_t                 item_o,
  output cfg_t                  cfg_o
);

  logic [CFG_DATA_W-1:0] alpha_lo_q, alpha_hi_q;
  logic [BASE_LEN_W-1:0] radix_q;
  logic                  base_valid_q, base_valid_d;
  logic [2*CFG_DATA_W-1:0] alpha;
  logic                  len_ok;

  assign cfg_ready_o = 1'b1;
  assign alpha       = {alpha_hi_q, alpha_lo_q};
  assign len_ok      = radix_q <= BASE_LEN_W'(MAX_BASE_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q   <= '0;
      alpha_hi_q   <= '0;
      radix_q      <= '0;
      base_valid_q <= 1'b0;
    end else begin
      base_valid_q <= base_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_ALPHA_LO: alpha_lo_q <= cfg_data_i;
          REG_ALPHA_HI: alpha_hi_q <= cfg_data_i;
          REG_BASE_LEN: radix_q <= cfg_data_i[BASE_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Alphabet check: length in range, no NUL or sign, no duplicate among used chars
  always_comb begin
    logic bad;
    bad = (radix_q < MIN_BASE_LEN) || !len_ok;
    for (int i = 0; i < MAX_BASE_LENGTH; i++) begin
      if (BASE_LEN_W'(i) < radix_q) begin
        if (alpha[8*i +: 8] == CH_NUL || alpha[8*i +: 8] == CH_PLUS ||
            alpha[8*i +: 8] == CH_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE_LENGTH; j++) begin
          if (BASE_LEN_W'(j) < radix_q && alpha[8*j +: 8] == alpha[8*i +: 8]) begin
            bad = 1'b1;
          end
        end
      end
    end
    base_valid_d = !bad;
  end

  // Parallel digit match, lowest position wins
  always_comb begin
    logic               found;
    logic [DIGIT_W-1:0] pos;
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < MAX_BASE_LENGTH; i++) begin
      if (!found && len_ok && BASE_LEN_W'(i) < radix_q &&
          alpha[8*i +: 8] == char_in_i) begin
        found = 1'b1;
        pos   = DIGIT_W'(i);
      end
    end
    item_o.is_digit = found;
    item_o.digit    = pos;
    item_o.last     = is_last_i;
    item_o.plus     = char_in_i == CH_PLUS;
    item_o.minus    = char_in_i == CH_MINUS;
    item_o.space    = char_in_i == CH_SPACE || char_in_i == CH_TAB ||
                      char_in_i == CH_LF || char_in_i == CH_VT ||
                      char_in_i == CH_FF || char_in_i == CH_CR;
  end

  assign item_valid_o = in_valid_i;
  assign in_ready_o   = item_ready_i;

  assign cfg_o.radix      = radix_q;
  assign cfg_o.base_valid = base_valid_q;

endmodule

>>> sv/sipab_queue.sv
module sipab_queue import sipab_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> sv/sipab_back.sv
module sipab_back import sipab_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  item_t            item_i,
  input  cfg_t             cfg_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] value_o,
  output logic             base_valid_o
);

  localparam logic [1:0] PhSpace  = 2'd0;
  localparam logic [1:0] PhSign   = 2'd1;
  localparam logic [1:0] PhDigit  = 2'd2;
  localparam logic [1:0] PhFrozen = 2'd3;

  logic [1:0]             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d, prod, signed_v;
  logic [WIDE_W-1:0]      wide;
  logic                   pop;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       value_q;
  logic                   base_valid_q;

  assign prod = acc_q * VALUE_WIDTH'(cfg_i.radix);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (phase_d == PhSpace && !item_i.space) phase_d = PhSign;
    if (phase_d == PhSign) begin
      if (item_i.minus) begin
        neg_d = ~neg_q;
      end else if (!item_i.plus) begin
        phase_d = PhDigit;
      end
    end
    if (phase_d == PhDigit) begin
      if (item_i.is_digit) begin
        acc_d = prod + VALUE_WIDTH'(item_i.digit);
      end else begin
        phase_d = PhFrozen;
      end
    end
  end

  assign signed_v = neg_d ? (~acc_d + VALUE_WIDTH'(1)) : acc_d;
  assign wide     = WIDE_W'(signed_v);

  // only a last character needs the output slot
  assign item_ready_o = !item_i.last || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSpace;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (item_i.last) begin
          phase_q <= PhSpace;
          neg_q   <= 1'b0;
          acc_q   <= '0;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          acc_q   <= acc_d;
        end
      end
      if (pop && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      value_q      <= cfg_i.base_valid ? wide[OUT_W-1:0] : '0;
      base_valid_q <= cfg_i.base_valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign base_valid_o = base_valid_q;

endmodule

>>> sv/signed_integer_parse_any_base_unit.sv
// Channel   Handshake                 Payload
// cfg       cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in        in_valid_i/in_ready_o     char_in_i, is_last_i
// out       out_valid_o/out_ready_i   value_o, base_valid_o
//
// One character per cycle while the output is not stalled; a result is offered
// once its last character has passed front classify (in the accept cycle), the
// two-entry queue and the back multiply-add into the result register.
// Throughput is set by the single multiply-add in the back end.
// Async active-low reset clears parser state, queue and config registers.
// Characters keep flowing while a result waits; only a last character stalls
// behind an untaken result, and the queue then fills after two requests.
module signed_integer_parse_any_base_unit import sipab_pkg::*; #(
  parameter int unsigned MAX_BASE_LENGTH = 16,
  parameter int unsigned VALUE_WIDTH     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CHAR_W-1:0]     char_in_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [OUT_W-1:0] value_o,
  output logic                  base_valid_o
);

  item_t            front_item, back_item;
  logic             front_valid, front_ready;
  logic             back_valid, back_ready;
  cfg_t             cfg;
  logic [OUT_W-1:0] value;

  sipab_front #(
    .MAX_BASE_LENGTH(MAX_BASE_LENGTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .char_in_i,
    .is_last_i,
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item),
    .cfg_o        (cfg)
  );

  sipab_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  sipab_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .cfg_i        (cfg),
    .out_valid_o,
    .out_ready_i,
    .value_o      (value),
    .base_valid_o
  );

  assign value_o = signed'(value);

endmodule

>>> sv/sipab_checker.sv
module sipab_checker import sipab_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [OUT_W-1:0]  value_o,
  input logic              base_valid_o
);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(base_valid_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !base_valid_o |-> value_o == '0)
    else $error("invalid base with nonzero value");

  // reset clears the result valid flag
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  // input side only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

endmodule

bind signed_integer_parse_any_base_unit sipab_checker u_sipab_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .value_o,
  .base_valid_o
);

>>> tb/signed_integer_parse_any_base_unit_test.sv
module signed_integer_parse_any_base_unit_test;
  import sipab_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1800;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {
    SKIP_BLANKS,
    READ_SIGNS,
    READ_DIGITS,
    FROZEN
  } parse_phase_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    base_ok;
  } parse_result_t;

  typedef enum logic {ROW_REG, ROW_CHAR} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [CHAR_W-1:0]     ch;
    bit                    last;
    bit                    typed;
    parse_result_t         want;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [CHAR_W-1:0]     char_in_i = '0;
  logic                  is_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] value_o;
  logic                  base_valid_o;

  signed_integer_parse_any_base_unit dut (.*);

  always #2 clk_i = ~clk_i;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_600_000;
    $display("[signed_integer_parse_any_base_unit] ERROR");
    $finish;
  end

  // Parser model state and its copy of the registers
  logic [CFG_DATA_W-1:0] alpha_lo_q = '0;
  logic [CFG_DATA_W-1:0] alpha_hi_q = '0;
  logic [BASE_LEN_W-1:0] radix_q = '0;
  parse_phase_e          phase_q = SKIP_BLANKS;
  bit                    negative_q = 1'b0;
  logic [OUT_W-1:0]      acc_q = '0;

  parse_result_t pending_results[$];
  script_row_t   script[$];
  int            chars_sent = 0;
  int            mismatches = 0;
  int unsigned   burst_left = 0;

  function automatic logic [CHAR_W-1:0] alpha_at(int k);
    return (k < 8) ? alpha_lo_q[k*8 +: 8] : alpha_hi_q[(k-8)*8 +: 8];
  endfunction

  function automatic bit alphabet_good();
    if (radix_q < MIN_BASE_LEN || radix_q > ALPHA_CHARS) return 1'b0;
    for (int i = 0; i < radix_q; i++) begin
      if (alpha_at(i) inside {CH_NUL, CH_PLUS, CH_MINUS}) return 1'b0;
      for (int j = i + 1; j < radix_q; j++)
        if (alpha_at(j) == alpha_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int digit_value(logic [CHAR_W-1:0] c);
    int n;
    n = (radix_q > ALPHA_CHARS) ? 0 : int'(radix_q);
    for (int i = 0; i < n; i++)
      if (alpha_at(i) == c) return i;
    return -1;
  endfunction

  function automatic bit is_blank(logic [CHAR_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  // Advances the parser by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [CHAR_W-1:0] c, input bit last,
                                    output parse_result_t r);
    int d;
    r = '0;
    if (phase_q == SKIP_BLANKS && !is_blank(c)) phase_q = READ_SIGNS;
    if (phase_q == READ_SIGNS) begin
      if (c == CH_MINUS) negative_q = ~negative_q;
      else if (c != CH_PLUS) phase_q = READ_DIGITS;
    end
    if (phase_q == READ_DIGITS) begin
      d = digit_value(c);
      if (d >= 0) acc_q = acc_q * OUT_W'(radix_q) + OUT_W'(d);
      else phase_q = FROZEN;
    end
    if (!last) return 1'b0;
    if (alphabet_good()) begin
      r.value = negative_q ? -acc_q : acc_q;
      r.base_ok = 1'b1;
    end
    phase_q = SKIP_BLANKS;
    negative_q = 1'b0;
    acc_q = '0;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result value %0d base_valid %0b",
                                value_o, base_valid_o));
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value)
          note_mismatch($sformatf("value expected %0d got %0d", want.value, value_o));
        if (base_valid_o !== want.base_ok)
          note_mismatch($sformatf("base_valid expected %0b got %0b",
                                  want.base_ok, base_valid_o));
      end
    end
  end

  // Receiver: switches between several stall patterns
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_beat = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_beat++;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= (rx_beat % 3 == 0);
    endcase
  end

  task automatic push_char(input logic [CHAR_W-1:0] c, input bit last, input bit typed,
                           input parse_result_t want);
    parse_result_t r;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    char_in_i <= c;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
    if (parse_char(c, last, r)) pending_results.push_back(typed ? want : r);
  endtask

  // Sender holds off until every expected result is in, then lets the pipe drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ALPHA_LO: alpha_lo_q = data;
      REG_ALPHA_HI: alpha_hi_q = data;
      REG_BASE_LEN: radix_q = data[BASE_LEN_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row = '{kind: ROW_REG, default: '0};
    row.reg_idx = idx;
    row.reg_data = data;
    script.push_back(row);
  endfunction

  function automatic void add_char(logic [CHAR_W-1:0] c, bit last, bit typed = 1'b0,
                                   logic signed [OUT_W-1:0] want_value = '0,
                                   bit want_ok = 1'b0);
    script_row_t row;
    row = '{kind: ROW_CHAR, default: '0};
    row.ch = c;
    row.last = last;
    row.typed = typed;
    row.want.value = want_value;
    row.want.base_ok = want_ok;
    script.push_back(row);
  endfunction

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k], k == s.len() - 1);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_sign();
    return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
  endfunction

  // New alphabet and radix; mostly valid, sometimes broken on purpose
  task automatic new_setting();
    bit                    seen [256];
    logic [CHAR_W-1:0]     chars [ALPHA_CHARS];
    logic [CHAR_W-1:0]     cand;
    logic [CFG_DATA_W-1:0] lo, hi;
    int                    radix, spot;
    case ($urandom_range(0, 9))
      0: radix = 2;
      1: radix = 16;
      2: radix = $urandom_range(0, 1);
      3: radix = $urandom_range(17, 31);
      default: radix = $urandom_range(2, 16);
    endcase
    seen = '{default: 1'b0};
    for (int k = 0; k < ALPHA_CHARS; k++) begin
      do cand = 8'($urandom_range(1, 255));
      while (cand == CH_PLUS || cand == CH_MINUS || seen[cand]);
      seen[cand] = 1'b1;
      chars[k] = cand;
    end
    for (int k = radix; k < ALPHA_CHARS; k++) chars[k] = 8'($urandom);
    if (radix >= 1 && radix <= ALPHA_CHARS && $urandom_range(0, 4) == 0) begin
      spot = $urandom_range(0, radix - 1);
      case ($urandom_range(0, 3))
        0: chars[spot] = CH_PLUS;
        1: chars[spot] = CH_MINUS;
        2: chars[spot] = CH_NUL;
        default: chars[spot] = chars[(spot + 1) % radix];
      endcase
    end
    for (int k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = chars[k];
      hi[k*8 +: 8] = chars[k + 8];
    end
    settle();
    write_reg(REG_ALPHA_LO, lo);
    settle();
    write_reg(REG_ALPHA_HI, hi);
    settle();
    write_reg(REG_BASE_LEN, CFG_DATA_W'(radix));
  endtask

  task automatic send_string();
    logic [CHAR_W-1:0] text[$];
    int                usable, n;
    usable = (radix_q > ALPHA_CHARS) ? 0 : int'(radix_q);
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(0, 3)) text.push_back(pick_blank());
      repeat ($urandom_range(0, 3)) text.push_back(pick_sign());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      repeat (n)
        text.push_back(usable > 0 ? alpha_at($urandom_range(0, usable - 1)) : 8'($urandom));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
    end else begin
      // noise: a loose mix of every character class
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0: text.push_back(pick_blank());
          1: text.push_back(pick_sign());
          2: text.push_back(usable > 0 ? alpha_at($urandom_range(0, usable - 1))
                                       : 8'($urandom));
          default: text.push_back(8'($urandom));
        endcase
      end
    end
    foreach (text[k]) push_char(text[k], k == text.size() - 1, 1'b0, '0);
  endtask

  initial begin
    // Out of reset the radix is zero, so any string gives an invalid base
    add_char("7", 1'b1, 1'b1, 0, 1'b0);
    // character 0 sits in the low byte, so the text reads backwards
    add_reg(REG_ALPHA_LO, "76543210");
    add_reg(REG_ALPHA_HI, "FEDCBA98");
    add_reg(REG_BASE_LEN, 10);
    add_char(CH_SPACE, 1'b0);
    add_char(CH_TAB, 1'b0);
    add_char(CH_LF, 1'b0);
    add_char(CH_VT, 1'b0);
    add_char(CH_FF, 1'b0);
    add_char(CH_CR, 1'b0);
    add_text("-+-42");
    add_text("-7x");
    add_char(8'hFF, 1'b1);
    add_char(CH_NUL, 1'b1);
    // full radix, value wraps to all ones
    add_reg(REG_BASE_LEN, 16);
    repeat (7) add_char("F", 1'b0);
    add_char("F", 1'b1, 1'b1, -1, 1'b1);
    add_reg(REG_BASE_LEN, 17);
    add_char("1", 1'b1, 1'b1, 0, 1'b0);
    add_reg(REG_BASE_LEN, 1);
    add_char("0", 1'b1, 1'b1, 0, 1'b0);

    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_data);
      end else begin
        push_char(script[i].ch, script[i].last, script[i].typed, script[i].want);
      end
    end

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      new_setting();
      repeat ($urandom_range(4, 20)) begin
        send_string();
        if ($urandom_range(0, 9) == 0) settle();
      end
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[signed_integer_parse_any_base_unit] OK");
    end else begin
      $display("[signed_integer_parse_any_base_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sipab_pkg.sv
sv/sipab_front.sv
sv/sipab_queue.sv
sv/sipab_back.sv
sv/signed_integer_parse_any_base_unit.sv
sv/sipab_checker.sv
tb/signed_integer_parse_any_base_unit_test.sv
